@@ design/dsrt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_pkg: shared types and constants
// Sizes, action codes, controller states and the structs that move between
// the controller and the row of table cells.
// ---------------------------------------------------------------------------
package dsrt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NAME_BYTES    = 33;
    // The longest name that is kept, in bytes.
    localparam int NAME_LEN      = NAME_BYTES - 1;
    localparam int NAME_SLOTS    = 32;
    localparam int NAME_W        = 8 * NAME_SLOTS;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = 5;
    localparam int ACT_W         = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_SKIP     = 3'd0,
        ACT_NEW      = 3'd1,
        ACT_STRONGER = 3'd2,
        ACT_WEAKER   = 3'd3,
        ACT_FULL     = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Record under search, held steady while the token walks the row.
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic signed [7:0] sig;
        logic [7:0]        chan;
        logic [7:0]        sec;
    } query_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             active;
        logic             found;
        logic             stronger;
        logic [IDX_W-1:0] idx;
    } tok_t;

endpackage
`default_nettype wire

@@ design/dsrt_rec_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_rec_if: scan record channel
// Valid/ready channel that carries one scan record per request.
// ---------------------------------------------------------------------------
interface dsrt_rec_if;
    logic              valid;
    logic              ready;
    logic              first_of_batch;
    logic              record_valid;
    logic [63:0]       name_part0;
    logic [63:0]       name_part1;
    logic [63:0]       name_part2;
    logic [63:0]       name_part3;
    logic signed [7:0] signal_level;
    logic [7:0]        radio_channel;
    logic [7:0]        security_kind;

    modport source (
        output valid, first_of_batch, record_valid, name_part0, name_part1,
               name_part2, name_part3, signal_level, radio_channel, security_kind,
        input  ready
    );

    modport sink (
        input  valid, first_of_batch, record_valid, name_part0, name_part1,
               name_part2, name_part3, signal_level, radio_channel, security_kind,
        output ready
    );
endinterface
`default_nettype wire

@@ design/dsrt_res_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_res_if: table result channel
// Valid/ready channel that carries one result per scan record.
// ---------------------------------------------------------------------------
interface dsrt_res_if;
    import dsrt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] slot_index;
    logic [ACT_W-1:0] action;
    logic [CNT_W-1:0] entry_count;
    logic             overflow;

    modport source (
        output valid, slot_index, action, entry_count, overflow,
        input  ready
    );

    modport sink (
        input  valid, slot_index, action, entry_count, overflow,
        output ready
    );
endinterface
`default_nettype wire

@@ design/dedup_scan_result_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dedup_scan_result_table: deduplicating scan result table
// Keeps one entry per network name in a row of cells; a search token walks
// the row to find a duplicate or the first free entry.
//
//   channel  role    payload
//   rec      sink    first_of_batch, record_valid, name_part0..3,
//                    signal_level, radio_channel, security_kind
//   res      source  slot_index, action, entry_count, overflow
//
// A searched record passes from acceptance through the start register, one
// register per cell while the token walks the row, the step that settles
// the counters and the load of the output register; a skipped record goes
// straight to that load. One record is in work at a time; rec.ready is low
// from acceptance until its result is loaded into the output register. A stall
// on res holds the block in its last step. Reset empties the table at once.
// ---------------------------------------------------------------------------
module dedup_scan_result_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dsrt_rec_if.sink   rec,
    dsrt_res_if.source res
);
    import dsrt_pkg::*;

    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] nm;
        logic              live;
        nm   = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_SLOTS; b++)
        begin
            if (b >= NAME_LEN || raw[8*b +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                nm[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return nm;
    endfunction

    state_t            state_reg;
    state_t            state_next;
    query_t            query_reg;
    logic              start_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  pend_slot_reg;
    act_t              pend_act_reg;
    logic              res_valid_reg;
    logic [CNT_W-1:0]  res_slot_reg;
    act_t              res_act_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_ovf_reg;

    logic [NAME_W-1:0] raw_name;
    logic              accept;
    logic              skip;
    logic              walk_done;
    logic              res_free;
    logic              res_load;
    logic              rec_ready;

    logic [CNT_W-1:0]  done_slot;
    act_t              done_act;
    logic [CNT_W-1:0]  done_used;
    logic              done_ovf;

    tok_t              tok_chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] tok_live;
    tok_t              last_tok;

    assign raw_name = {rec.name_part3, rec.name_part2, rec.name_part1, rec.name_part0};
    assign skip     = !rec.record_valid || (rec.name_part0[7:0] == 8'h00);
    assign accept   = rec.valid && rec_ready;
    assign res_free = !res_valid_reg || res.ready;
    assign last_tok = tok_chain[TABLE_ENTRIES];

    // ---- row of cells ----
    always_comb
    begin
        tok_chain[0]        = '0;
        tok_chain[0].active = start_reg;
    end

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        dsrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(gi)),
            .used     (used_reg),
            .query    (query_reg),
            .tok_in   (tok_chain[gi]),
            .tok_out  (tok_chain[gi+1])
        );
        assign tok_live[gi] = tok_chain[gi+1].active;
    end

    // ---- control ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rec.valid)
                begin
                    state_next = skip ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_tok.active)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rec_ready = 1'b0;
        walk_done = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   rec_ready = 1'b1;
            ST_WALK:   walk_done = last_tok.active;
            ST_FINISH: res_load  = res_free;
            default:   rec_ready = 1'b0;
        endcase
    end

    assign rec.ready = rec_ready;

    // Outcome once the token has left the last cell.
    always_comb
    begin
        done_slot = CNT_W'(TABLE_ENTRIES);
        done_used = used_reg;
        done_ovf  = ovf_reg;
        if (last_tok.found)
        begin
            if (last_tok.stronger)
            begin
                done_act  = ACT_STRONGER;
                done_slot = CNT_W'(last_tok.idx);
            end
            else
            begin
                // A weaker duplicate seen while the table is full also
                // marks the batch as overflowed.
                done_act = ACT_WEAKER;
                if (used_reg >= CNT_W'(TABLE_ENTRIES))
                begin
                    done_ovf = 1'b1;
                end
            end
        end
        else if (used_reg >= CNT_W'(TABLE_ENTRIES))
        begin
            done_act = ACT_FULL;
            done_ovf = 1'b1;
        end
        else
        begin
            done_act  = ACT_NEW;
            done_slot = used_reg;
            done_used = used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept && !skip;
            if (accept && rec.first_of_batch)
            begin
                used_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (walk_done)
            begin
                used_reg <= done_used;
                ovf_reg  <= done_ovf;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg.name <= canon_name(raw_name);
            query_reg.sig  <= rec.signal_level;
            query_reg.chan <= rec.radio_channel;
            query_reg.sec  <= rec.security_kind;
            pend_slot_reg  <= CNT_W'(TABLE_ENTRIES);
            pend_act_reg   <= ACT_SKIP;
        end
        else if (walk_done)
        begin
            pend_slot_reg <= done_slot;
            pend_act_reg  <= done_act;
        end
        if (res_load)
        begin
            res_slot_reg  <= pend_slot_reg;
            res_act_reg   <= pend_act_reg;
            res_count_reg <= used_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.slot_index  = res_slot_reg;
    assign res.action      = res_act_reg;
    assign res.entry_count = res_count_reg;
    assign res.overflow    = res_ovf_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_live))
        else $error("more than one search token in the row");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.entry_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_new_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == ACT_NEW |->
            res.slot_index == CNT_W'(res.entry_count - 1'b1))
        else $error("new entry not at the end of the table");

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == ACT_FULL |->
            res.overflow && res.entry_count == CNT_W'(TABLE_ENTRIES))
        else $error("full drop without overflow");

endmodule
`default_nettype wire

@@ design/dsrt_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_cell: one table entry
// Holds one entry, compares it against the passing search token and
// registers the token on to the next cell. Performs its own update or fill.
// ---------------------------------------------------------------------------
module dsrt_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [dsrt_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [dsrt_pkg::CNT_W-1:0] used,
    input  wire dsrt_pkg::query_t      query,
    input  wire dsrt_pkg::tok_t        tok_in,
    output dsrt_pkg::tok_t             tok_out
);
    import dsrt_pkg::*;

    logic [NAME_W-1:0] name_reg;
    logic signed [7:0] sig_reg;
    logic [7:0]        chan_reg;
    logic [7:0]        sec_reg;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic              searching;
    logic              hit;
    logic              fresh;
    logic              beats;

    // Only entries below the fill count hold a name; the first free entry
    // takes a new name once every filled entry has been passed.
    assign searching = tok_in.active && !tok_in.found;
    assign hit       = searching && (CNT_W'(cell_idx) < used) && (name_reg == query.name);
    assign fresh     = searching && (CNT_W'(cell_idx) == used);
    assign beats     = $signed(query.sig) > $signed(sig_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found    = 1'b1;
            tok_next.stronger = beats;
            tok_next.idx      = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fresh)
        begin
            name_reg <= query.name;
        end
        if (fresh || (hit && beats))
        begin
            sig_reg  <= query.sig;
            chan_reg <= query.chan;
            sec_reg  <= query.sec;
        end
    end

    assign tok_out = tok_reg;

    a_no_hit_and_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !(hit && fresh))
        else $error("cell both matched and filled");

    a_found_idx_behind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_in.active && tok_in.found |=> tok_reg.found && tok_reg.idx == $past(tok_in.idx))
        else $error("cell disturbed an earlier match");

    a_hit_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> CNT_W'(cell_idx) < used)
        else $error("match on an entry above the fill count");

endmodule
`default_nettype wire

@@ test/dsrt_table_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_table_checker: result checker for the scan result table
// Watches both channels, keeps its own copy of the table, works out the
// outcome of every accepted request and compares each returned result with
// the oldest outcome still due.
// ---------------------------------------------------------------------------
module dsrt_table_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    dsrt_rec_if       rec,
    dsrt_res_if       res,
    output int        mismatch_count,
    output int        results_due
);
    import dsrt_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0] slot;
        act_t             act;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } outcome_t;

    logic [NAME_W-1:0] known_name [TABLE_ENTRIES];
    logic signed [7:0] known_sig  [TABLE_ENTRIES];
    logic [7:0]        known_chan [TABLE_ENTRIES];
    logic [7:0]        known_sec  [TABLE_ENTRIES];
    int                used_count;
    logic              full_seen;
    outcome_t          outcomes_due [$];
    int                fails = 0;
    int                due_count = 0;

    assign mismatch_count = fails;
    assign results_due    = due_count;

    // The stored name stops at the first zero byte or at the length limit.
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] nm;
        bit                ended;
        nm    = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_SLOTS; b++)
        begin
            if (b >= NAME_LEN || raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                nm[8*b +: 8] = raw[8*b +: 8];
        end
        return nm;
    endfunction

    function automatic outcome_t place_record(
        input logic              fob,
        input logic              rv,
        input logic [NAME_W-1:0] raw,
        input logic signed [7:0] sig,
        input logic [7:0]        chan,
        input logic [7:0]        sec
    );
        outcome_t          o;
        logic [NAME_W-1:0] nm;
        int                hit;
        if (fob)
        begin
            used_count = 0;
            full_seen  = 1'b0;
        end
        nm     = trim_name(raw);
        o.slot = CNT_W'(TABLE_ENTRIES);
        o.act  = ACT_SKIP;
        if (rv && nm[7:0] != 8'h00)
        begin
            hit = -1;
            for (int i = 0; i < used_count; i++)
                if (hit < 0 && known_name[i] == nm)
                    hit = i;
            if (hit >= 0)
            begin
                if (sig > known_sig[hit])
                begin
                    known_sig[hit]  = sig;
                    known_chan[hit] = chan;
                    known_sec[hit]  = sec;
                    o.slot          = CNT_W'(hit);
                    o.act           = ACT_STRONGER;
                end
                else
                begin
                    // A weaker duplicate still raises the flag when the table is full.
                    if (used_count >= TABLE_ENTRIES)
                        full_seen = 1'b1;
                    o.act = ACT_WEAKER;
                end
            end
            else if (used_count >= TABLE_ENTRIES)
            begin
                full_seen = 1'b1;
                o.act     = ACT_FULL;
            end
            else
            begin
                known_name[used_count] = nm;
                known_sig[used_count]  = sig;
                known_chan[used_count] = chan;
                known_sec[used_count]  = sec;
                o.slot                 = CNT_W'(used_count);
                o.act                  = ACT_NEW;
                used_count++;
            end
        end
        o.count = CNT_W'(used_count);
        o.ovf   = full_seen;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            used_count = 0;
            full_seen  = 1'b0;
            outcomes_due.delete();
        end
        else
        begin
            if (rec.valid && rec.ready)
                outcomes_due.push_back(place_record(rec.first_of_batch, rec.record_valid,
                    {rec.name_part3, rec.name_part2, rec.name_part1, rec.name_part0},
                    rec.signal_level, rec.radio_channel, rec.security_kind));
            if (res.valid && res.ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result returned with no request outstanding");
                    fails++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (res.slot_index !== want.slot)
                    begin
                        $error("slot_index: expected %0d, got %0d", want.slot, res.slot_index);
                        fails++;
                    end
                    if (res.action !== want.act)
                    begin
                        $error("action: expected %0d, got %0d", want.act, res.action);
                        fails++;
                    end
                    if (res.entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               res.entry_count);
                        fails++;
                    end
                    if (res.overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0d, got %0d", want.ovf, res.overflow);
                        fails++;
                    end
                end
            end
        end
        due_count = outcomes_due.size();
    end

endmodule
`default_nettype wire

@@ test/tb_dedup_scan_result_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_dedup_scan_result_table: testbench for the scan result table
// Drives a directed run through the table's corner cases, then random batches
// of scan requests drawn from a small name pool so that duplicates, full
// tables and overflow occur often. Both sides pause at random, and once the
// result side holds off long enough to back up the request side.
// ---------------------------------------------------------------------------
module tb_dedup_scan_result_table;
    import dsrt_pkg::*;

    localparam int POOL_SIZE  = 24;
    localparam int RANDOM_ITEMS = 2000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   records_sent = 0;

    logic [NAME_W-1:0] pool_name [POOL_SIZE];
    int                pool_len  [POOL_SIZE];

    dsrt_rec_if rec ();
    dsrt_res_if res ();

    dedup_scan_result_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec),
        .res   (res)
    );

    dsrt_table_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec            (rec),
        .res            (res),
        .mismatch_count (fail_count),
        .results_due    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [NAME_W-1:0] random_bits();
        logic [NAME_W-1:0] v;
        for (int w = 0; w < NAME_W / 32; w++)
            v[32*w +: 32] = $urandom;
        return v;
    endfunction

    function automatic logic [NAME_W-1:0] fresh_name(input int len);
        logic [NAME_W-1:0] nm;
        nm = '0;
        for (int b = 0; b < len; b++)
            nm[8*b +: 8] = 8'($urandom_range(1, 255));
        return nm;
    endfunction

    // Half the time, fill the bytes past the terminator with junk.
    function automatic logic [NAME_W-1:0] dirty_name(input logic [NAME_W-1:0] nm,
                                                     input int len);
        logic [NAME_W-1:0] raw;
        raw = nm;
        if (len < NAME_SLOTS && $urandom_range(0, 1) == 1)
            for (int b = len + 1; b < NAME_SLOTS; b++)
                raw[8*b +: 8] = 8'($urandom);
        return raw;
    endfunction

    task automatic refill_pool();
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_len[p]  = ($urandom_range(0, 3) == 0) ? NAME_SLOTS : $urandom_range(1, 8);
            pool_name[p] = fresh_name(pool_len[p]);
        end
    endtask

    task automatic send_record(
        input logic              fob,
        input logic              rv,
        input logic [NAME_W-1:0] raw,
        input logic [7:0]        sig,
        input logic [7:0]        chan,
        input logic [7:0]        sec
    );
        int gap;
        gap = ((records_sent / 200) % 4 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            rec.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rec.first_of_batch <= fob;
        rec.record_valid   <= rv;
        rec.name_part0     <= raw[63:0];
        rec.name_part1     <= raw[127:64];
        rec.name_part2     <= raw[191:128];
        rec.name_part3     <= raw[255:192];
        rec.signal_level   <= sig;
        rec.radio_channel  <= chan;
        rec.security_kind  <= sec;
        rec.valid          <= 1'b1;
        do @(posedge clk); while (!(rec.valid && rec.ready));
        records_sent++;
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int hold;
        int taken;
        taken = 0;
        res.ready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // One long hold backs the block up against the request side.
            if (taken == 300)
                hold = 400;
            else if ((taken / 200) % 4 == 0 || (taken / 200) % 4 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 9);
            if (hold > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid && res.ready));
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [NAME_W-1:0] full_name;
        logic [NAME_W-1:0] raw;
        logic              fob;
        logic              rv;
        int                drawn;
        int                p;

        rst_n              = 1'b0;
        rec.valid          <= 1'b0;
        rec.first_of_batch <= 1'b0;
        rec.record_valid   <= 1'b0;
        rec.name_part0     <= '0;
        rec.name_part1     <= '0;
        rec.name_part2     <= '0;
        rec.name_part3     <= '0;
        rec.signal_level   <= '0;
        rec.radio_channel  <= '0;
        rec.security_kind  <= '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        full_name = {NAME_SLOTS{8'hFF}};
        send_record(1'b1, 1'b1, NAME_W'(8'h41), 8'h80, 8'h00, 8'h00);
        // Equal signal counts as weaker.
        send_record(1'b0, 1'b1, NAME_W'(8'h41), 8'h80, 8'h01, 8'h01);
        send_record(1'b0, 1'b1, NAME_W'(8'h41), 8'h7F, 8'hFF, 8'hFF);
        send_record(1'b0, 1'b0, full_name, 8'h00, 8'h00, 8'h00);
        send_record(1'b0, 1'b1, {{(NAME_SLOTS-1){8'hA5}}, 8'h00}, 8'h05, 8'h06, 8'h07);
        send_record(1'b0, 1'b1, full_name, 8'h00, 8'hFF, 8'hFF);
        // Same bytes one shorter is a different name.
        send_record(1'b0, 1'b1, {8'h00, {(NAME_SLOTS-1){8'hFF}}}, 8'h01, 8'h0B, 8'h02);
        // Junk after the terminator must not matter for matching.
        send_record(1'b0, 1'b1, {{(NAME_SLOTS-2){8'h5C}}, 8'h00, 8'h41}, 8'hFF, 8'h03,
                    8'h04);
        for (int k = 0; k < TABLE_ENTRIES - 3; k++)
            send_record(1'b0, 1'b1, NAME_W'({8'h42, 8'(8'h61 + k)}), 8'($urandom),
                        8'(k), 8'(k + 1));
        send_record(1'b0, 1'b1, NAME_W'(16'h7A7A), 8'h10, 8'h01, 8'h01);
        send_record(1'b0, 1'b1, NAME_W'(8'h41), 8'h00, 8'h01, 8'h01);
        send_record(1'b0, 1'b1, full_name, 8'h7F, 8'h24, 8'h03);
        send_record(1'b1, 1'b0, NAME_W'(8'h41), 8'h00, 8'h00, 8'h00);

        refill_pool();
        drawn = 0;
        while (drawn < RANDOM_ITEMS)
        begin
            fob = ($urandom_range(0, 39) == 0);
            rv  = ($urandom_range(0, 19) != 0);
            if (fob && $urandom_range(0, 1) == 1)
                refill_pool();
            if ($urandom_range(0, 99) < 4)
            begin
                raw      = random_bits();
                raw[7:0] = 8'h00;
            end
            else
            begin
                p   = $urandom_range(0, POOL_SIZE - 1);
                raw = dirty_name(pool_name[p], pool_len[p]);
            end
            send_record(fob, rv, raw, 8'($urandom), 8'($urandom), 8'($urandom));
            drawn++;
        end
        rec.valid <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
